// ----- design/acr_pkg.sv -----
// ----------------------------------------------------------------------------
// acr_pkg: shared types and constants of the capture ring
// Request kinds, register indexes, frame store sizes and the structs passed
// between the front, the back and the top level.
// ----------------------------------------------------------------------------
`default_nettype none
package acr_pkg;

   localparam int DEPTH    = 4096;
   localparam int ADDR_W   = 12;
   localparam int CNT_W    = 13;
   localparam int SAMPLE_W = 24;
   localparam int ACC_W    = 60;
   localparam int DIV_W    = 14;
   localparam int ROOT_W   = 48;
   localparam int RATIO_W  = 17;

   localparam logic [1:0] KIND_PUSH  = 2'd0;
   localparam logic [1:0] KIND_STATS = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;
   localparam logic [1:0] KIND_NONE  = 2'd3;

   localparam logic [1:0] CSR_CAPACITY  = 2'd0;
   localparam logic [1:0] CSR_CHANNELS  = 2'd1;
   localparam logic [1:0] CSR_THRESHOLD = 2'd2;

   localparam logic [CNT_W-1:0] CAPACITY_RESET  = 13'd4096;
   localparam logic [1:0]       CHANNELS_RESET  = 2'd2;
   localparam logic [22:0]      THRESHOLD_RESET = 23'd8;

   typedef struct packed {
      logic [CNT_W-1:0] capacity;
      logic [1:0]       active_channels;
      logic [22:0]      silence_threshold;
   } cfg_type;

   typedef struct packed {
      logic [1:0]                 kind;
      logic signed [SAMPLE_W-1:0] main_left;
      logic signed [SAMPLE_W-1:0] main_right;
      logic signed [SAMPLE_W-1:0] side_left;
      logic signed [SAMPLE_W-1:0] side_right;
      logic                       side_valid;
      logic [CNT_W-1:0]           request_count;
      logic [ADDR_W-1:0]          read_offset;
   } cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0]           window_frames;
      logic                       side_all_present;
      logic [SAMPLE_W-1:0]        main_rms;
      logic [SAMPLE_W-1:0]        side_rms;
      logic [RATIO_W-1:0]         valid_ratio;
      logic signed [SAMPLE_W-1:0] out_main_left;
      logic signed [SAMPLE_W-1:0] out_main_right;
      logic signed [SAMPLE_W-1:0] out_side_left;
      logic signed [SAMPLE_W-1:0] out_side_right;
      logic                       out_of_window;
   } result_type;

endpackage
`default_nettype wire

// ----- design/acr_front.sv -----
// ----------------------------------------------------------------------------
// acr_front: request intake and command queue
// Decodes the request kind, drops none-kind requests and holds up to two
// commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module acr_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire acr_pkg::cmd_type in_cmd,
   output logic                  q_valid,
   output acr_pkg::cmd_type      q_cmd,
   input  wire logic             q_pop
);
   import acr_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push_q;
   logic       pop_q;

   assign in_ready = (count_ff != 2'd2);
   assign push_q   = in_valid && in_ready && (in_cmd.kind != KIND_NONE);
   assign pop_q    = q_pop && (count_ff != 2'd0);
   assign q_valid  = (count_ff != 2'd0);
   assign q_cmd    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_q ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_q ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push_q} - {1'b0, pop_q};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_q) begin
         slot_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule
`default_nettype wire

// ----- design/acr_div.sv -----
// ----------------------------------------------------------------------------
// acr_div: bit-serial restoring divider
// One quotient bit per cycle; done pulses when the quotient is ready.
// ----------------------------------------------------------------------------
`default_nettype none
module acr_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [acr_pkg::ACC_W-1:0]   dividend,
   input  wire logic [acr_pkg::DIV_W-1:0]   divisor,
   output logic                             done,
   output logic [acr_pkg::ACC_W-1:0]        quotient
);
   import acr_pkg::*;

   logic [ACC_W-1:0] num_ff;
   logic [DIV_W-1:0] rem_ff;
   logic [DIV_W-1:0] dvs_ff;
   logic [5:0]       cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DIV_W:0]   trial;
   logic             fits;
   logic [DIV_W:0]   diff;

   assign trial    = {rem_ff, num_ff[ACC_W-1]};
   assign fits     = (trial >= {1'b0, dvs_ff});
   assign diff     = trial - {1'b0, dvs_ff};
   assign done     = done_ff;
   assign quotient = num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'(ACC_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         num_ff <= {num_ff[ACC_W-2:0], fits};
         rem_ff <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      end
   end

endmodule
`default_nettype wire

// ----- design/acr_sqrt.sv -----
// ----------------------------------------------------------------------------
// acr_sqrt: digit-by-digit integer square root
// One result bit per cycle over a 48-bit operand.
// ----------------------------------------------------------------------------
`default_nettype none
module acr_sqrt (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [acr_pkg::ROOT_W-1:0]   radicand,
   output logic                              done,
   output logic [acr_pkg::SAMPLE_W-1:0]      root
);
   import acr_pkg::*;

   logic [ROOT_W-1:0] x_ff;
   logic [ROOT_W-1:0] res_ff;
   logic [ROOT_W-1:0] bit_ff;
   logic [4:0]        cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [ROOT_W-1:0] trial;
   logic              fits;

   assign trial = res_ff + bit_ff;
   assign fits  = (x_ff >= trial);
   assign done  = done_ff;
   assign root  = res_ff[SAMPLE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 5'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'(ROOT_W / 2 - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff   <= radicand;
         res_ff <= '0;
         bit_ff <= {2'b01, {(ROOT_W-2){1'b0}}};
      end else if (busy_ff) begin
         if (fits) begin
            x_ff   <= x_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

endmodule
`default_nettype wire

// ----- design/acr_back.sv -----
// ----------------------------------------------------------------------------
// acr_back: frame store and command execution
// Writes pushed frames, walks the window for statistics and reads frames.
// ----------------------------------------------------------------------------
`default_nettype none
module acr_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire acr_pkg::cfg_type    cfg,
   input  wire logic                q_valid,
   input  wire acr_pkg::cmd_type    q_cmd,
   output logic                     q_pop,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output acr_pkg::result_type      out_data
);
   import acr_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_WALK   = 3'd1;
   localparam logic [2:0] S_DRAIN  = 3'd2;
   localparam logic [2:0] S_DIV    = 3'd3;
   localparam logic [2:0] S_SQRT   = 3'd4;
   localparam logic [2:0] S_RDWAIT = 3'd5;
   localparam logic [2:0] S_RDOUT  = 3'd6;

   localparam int ENTRY_W = 4 * SAMPLE_W + 1;

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rdata_ff;
   logic [ENTRY_W-1:0] wdata;

   logic [2:0]          state_ff;
   logic [ADDR_W-1:0]   wp_ff;
   logic [CNT_W-1:0]    fill_ff;
   logic [ADDR_W-1:0]   pos_ff;
   logic [CNT_W-1:0]    left_ff;
   logic [2:0]          phase_ff;
   logic [CNT_W-1:0]    nwin_ff;
   logic [ACC_W-1:0]    acc_main_ff;
   logic [ACC_W-1:0]    acc_side_ff;
   logic [CNT_W-1:0]    valid_cnt_ff;
   logic [CNT_W-1:0]    pres_cnt_ff;
   logic [2*SAMPLE_W-1:0] mul_ff;
   logic                mul_vld_ff;
   logic                mul_side_ff;
   logic [1:0]          op_ff;
   logic [SAMPLE_W-1:0] main_rms_ff;
   logic [SAMPLE_W-1:0] side_rms_ff;
   logic                out_valid_ff;
   result_type          out_ff;
   result_type          res_init;

   logic [CNT_W-1:0]    cap_eff;
   logic                ch2;
   logic [ADDR_W-1:0]   wp_eff;
   logic [CNT_W-1:0]    avail;
   logic [CNT_W-1:0]    want;
   logic [CNT_W-1:0]    n_c;
   logic [CNT_W-1:0]    st13;
   logic [CNT_W:0]      rsum;
   logic [ADDR_W-1:0]   rd_pos;
   logic [CNT_W-1:0]    wp_inc;
   logic [CNT_W-1:0]    pos_inc;
   logic [ADDR_W-1:0]   pos_next;
   logic                do_push;

   logic signed [SAMPLE_W-1:0] r_m0, r_m1, r_s0, r_s1;
   logic                       r_mask;
   logic [SAMPLE_W-1:0]        mg_m0, mg_m1, mg_s0, mg_s1;
   logic [SAMPLE_W-1:0]        mag_sel;

   logic                div_start;
   logic [1:0]          div_op;
   logic [ACC_W-1:0]    div_num;
   logic [DIV_W-1:0]    div_den;
   logic                div_done;
   logic [ACC_W-1:0]    div_q;
   logic                sq_start;
   logic                sq_done;
   logic [SAMPLE_W-1:0] sq_root;

   function automatic logic [SAMPLE_W-1:0] mag(input logic signed [SAMPLE_W-1:0] v);
      logic [SAMPLE_W-1:0] u;
      u = v;
      return v[SAMPLE_W-1] ? (~u + 1'b1) : u;
   endfunction

   always_comb begin
      if (cfg.capacity == '0) cap_eff = 13'd1;
      else if (cfg.capacity > CNT_W'(DEPTH)) cap_eff = CNT_W'(DEPTH);
      else cap_eff = cfg.capacity;
      ch2     = (cfg.active_channels >= 2'd2);
      wp_eff  = ({1'b0, wp_ff} < cap_eff) ? wp_ff : '0;
      avail   = (fill_ff < cap_eff) ? fill_ff : cap_eff;
      want    = (q_cmd.request_count > cap_eff) ? cap_eff : q_cmd.request_count;
      n_c     = (avail < want) ? avail : want;
      st13    = ({1'b0, wp_eff} >= n_c) ? ({1'b0, wp_eff} - n_c)
                                        : ({1'b0, wp_eff} + cap_eff - n_c);
      rsum    = {1'b0, st13} + {2'b00, q_cmd.read_offset};
      rd_pos  = (rsum >= {1'b0, cap_eff}) ? ADDR_W'(rsum - {1'b0, cap_eff})
                                          : rsum[ADDR_W-1:0];
      wp_inc  = {1'b0, wp_eff} + 13'd1;
      pos_inc = {1'b0, pos_ff} + 13'd1;
      pos_next = (pos_inc == cap_eff) ? '0 : pos_inc[ADDR_W-1:0];
   end

   always_comb begin
      res_init               = '0;
      res_init.window_frames = n_c;
      res_init.out_of_window = (q_cmd.kind == KIND_READ)
                            && ({1'b0, q_cmd.read_offset} >= n_c);
   end

   assign q_pop   = (state_ff == S_IDLE) && q_valid
                 && ((q_cmd.kind == KIND_PUSH) || !out_valid_ff);
   assign do_push = q_pop && (q_cmd.kind == KIND_PUSH);

   assign wdata = {q_cmd.side_valid,
                   (q_cmd.side_valid && ch2) ? q_cmd.side_right : '0,
                   q_cmd.side_valid ? q_cmd.side_left : '0,
                   ch2 ? q_cmd.main_right : '0,
                   q_cmd.main_left};

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wp_eff] <= wdata;
      end
      rdata_ff <= mem[pos_ff];
   end

   always_comb begin
      r_m0   = rdata_ff[SAMPLE_W-1:0];
      r_m1   = ch2 ? rdata_ff[2*SAMPLE_W-1:SAMPLE_W] : '0;
      r_s0   = rdata_ff[3*SAMPLE_W-1:2*SAMPLE_W];
      r_s1   = ch2 ? rdata_ff[4*SAMPLE_W-1:3*SAMPLE_W] : '0;
      r_mask = rdata_ff[ENTRY_W-1];
      mg_m0  = mag(r_m0);
      mg_m1  = mag(r_m1);
      mg_s0  = mag(r_s0);
      mg_s1  = mag(r_s1);
      unique case (phase_ff)
         3'd1:    mag_sel = mg_m0;
         3'd2:    mag_sel = mg_m1;
         3'd3:    mag_sel = mg_s0;
         3'd4:    mag_sel = mg_s1;
         default: mag_sel = '0;
      endcase
   end

   always_comb begin
      div_op    = (state_ff == S_DRAIN) ? 2'd0 : (op_ff + 2'd1);
      div_start = (state_ff == S_DRAIN)
               || ((state_ff == S_SQRT) && sq_done && (op_ff != 2'd2));
      sq_start  = (state_ff == S_DIV) && div_done && (op_ff != 2'd2);
      unique case (div_op)
         2'd0:    div_num = acc_main_ff;
         2'd1:    div_num = acc_side_ff;
         default: div_num = ACC_W'({valid_cnt_ff, 16'd0});
      endcase
      div_den = (div_op == 2'd2 || !ch2) ? {1'b0, nwin_ff} : {nwin_ff, 1'b0};
   end

   acr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   acr_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (div_q[ROOT_W-1:0]),
      .done     (sq_done),
      .root     (sq_root)
   );

   always_ff @(posedge clock) begin
      mul_ff <= mag_sel * mag_sel;
      if (q_pop && q_cmd.kind == KIND_STATS) begin
         acc_main_ff  <= '0;
         acc_side_ff  <= '0;
         valid_cnt_ff <= '0;
         pres_cnt_ff  <= '0;
      end else begin
         if (mul_vld_ff && !mul_side_ff) acc_main_ff <= acc_main_ff + ACC_W'(mul_ff);
         if (mul_vld_ff && mul_side_ff)  acc_side_ff <= acc_side_ff + ACC_W'(mul_ff);
         if (state_ff == S_WALK && phase_ff == 3'd1) begin
            if (((mg_m0 > {1'b0, cfg.silence_threshold})
                 || (mg_m1 > {1'b0, cfg.silence_threshold}))
                && ((mg_s0 > {1'b0, cfg.silence_threshold})
                 || (mg_s1 > {1'b0, cfg.silence_threshold}))) begin
               valid_cnt_ff <= valid_cnt_ff + 13'd1;
            end
            if (r_mask) pres_cnt_ff <= pres_cnt_ff + 13'd1;
         end
      end
      if (state_ff == S_SQRT && sq_done && op_ff == 2'd0) main_rms_ff <= sq_root;
      if (state_ff == S_SQRT && sq_done && op_ff == 2'd1) side_rms_ff <= sq_root;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         fill_ff      <= '0;
         pos_ff       <= '0;
         left_ff      <= '0;
         phase_ff     <= '0;
         nwin_ff      <= '0;
         op_ff        <= '0;
         mul_vld_ff   <= 1'b0;
         mul_side_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mul_vld_ff  <= (state_ff == S_WALK) && (phase_ff != 3'd0);
         mul_side_ff <= (phase_ff >= 3'd3);
         if (out_valid_ff && out_ready) out_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (q_pop) begin
                  nwin_ff <= n_c;
                  unique case (q_cmd.kind)
                     KIND_PUSH: begin
                        wp_ff   <= (wp_inc == cap_eff) ? '0 : wp_inc[ADDR_W-1:0];
                        fill_ff <= (fill_ff < cap_eff) ? fill_ff + 13'd1 : cap_eff;
                     end
                     KIND_STATS: begin
                        out_ff <= res_init;
                        if (n_c == '0) begin
                           out_valid_ff <= 1'b1;
                        end else begin
                           pos_ff   <= st13[ADDR_W-1:0];
                           left_ff  <= n_c;
                           phase_ff <= 3'd0;
                           state_ff <= S_WALK;
                        end
                     end
                     default: begin
                        out_ff <= res_init;
                        if (res_init.out_of_window) begin
                           out_valid_ff <= 1'b1;
                        end else begin
                           pos_ff   <= rd_pos;
                           state_ff <= S_RDWAIT;
                        end
                     end
                  endcase
               end
            end
            S_WALK: begin
               if (phase_ff == 3'd4) begin
                  phase_ff <= 3'd0;
                  if (left_ff == 13'd1) begin
                     state_ff <= S_DRAIN;
                  end else begin
                     left_ff <= left_ff - 13'd1;
                     pos_ff  <= pos_next;
                  end
               end else begin
                  phase_ff <= phase_ff + 3'd1;
               end
            end
            S_DRAIN: begin
               op_ff    <= 2'd0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (div_done) begin
                  if (op_ff == 2'd2) begin
                     out_ff.side_all_present <= (pres_cnt_ff == nwin_ff);
                     out_ff.main_rms         <= main_rms_ff;
                     out_ff.side_rms         <= side_rms_ff;
                     out_ff.valid_ratio      <= div_q[RATIO_W-1:0];
                     out_valid_ff            <= 1'b1;
                     state_ff                <= S_IDLE;
                  end else begin
                     state_ff <= S_SQRT;
                  end
               end
            end
            S_SQRT: begin
               if (sq_done) begin
                  op_ff    <= op_ff + 2'd1;
                  state_ff <= S_DIV;
               end
            end
            S_RDWAIT: begin
               state_ff <= S_RDOUT;
            end
            S_RDOUT: begin
               out_ff.out_main_left  <= r_m0;
               out_ff.out_main_right <= r_m1;
               out_ff.out_side_left  <= r_s0;
               out_ff.out_side_right <= r_s1;
               out_valid_ff          <= 1'b1;
               state_ff              <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(DEPTH))
      else $error("fill count beyond store depth");

   a_walk_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (left_ff != '0) && ({1'b0, pos_ff} < cap_eff))
      else $error("window walk out of range");

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !q_pop)
      else $error("command taken while busy");

endmodule
`default_nettype wire

// ----- design/audio_capture_ring_with_snapshot_stats.sv -----
// ----------------------------------------------------------------------------
// audio_capture_ring_with_snapshot_stats: capture ring with window statistics
// Circular store of main and sidechain frames with RMS and presence stats.
// ----------------------------------------------------------------------------
// A push is written to the store as soon as it is taken. Pushes stream at one
// request per cycle via a two-entry command queue while the back end is idle.
// A read loads the store address, waits for the registered store read and fills
// the output register. Stats walk each frame of the n-frame window in phases on
// the single-port store read and the one shared squaring multiplier, then run
// three bit-serial divisions and two bit-serial square roots. Results wait in
// an output register while pushes go on. The store needs no clearing on reset.
// ----------------------------------------------------------------------------
`default_nettype none
module audio_capture_ring_with_snapshot_stats (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // main_left, main_right, side_left, side_right, side_valid, request_count,
   // read_offset, zero fill
   input  wire logic [127:0]  req_tdata,
   // req_type
   input  wire logic [1:0]    req_tuser,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // window_frames, side_all_present, main_rms, side_rms, valid_ratio,
   // out_main_left, out_main_right, out_side_left, out_side_right, out_of_window
   output logic [175:0]       rsp_tdata,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [1:0]    csr_index,
   input  wire logic [22:0]   csr_data
);
   import acr_pkg::*;

   cfg_type    cfg_ff;
   cmd_type    in_cmd;
   cmd_type    q_cmd;
   logic       q_valid;
   logic       q_pop;
   result_type res;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.capacity          <= CAPACITY_RESET;
         cfg_ff.active_channels   <= CHANNELS_RESET;
         cfg_ff.silence_threshold <= THRESHOLD_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CAPACITY:  cfg_ff.capacity          <= csr_data[CNT_W-1:0];
            CSR_CHANNELS:  cfg_ff.active_channels   <= csr_data[1:0];
            CSR_THRESHOLD: cfg_ff.silence_threshold <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      in_cmd.kind          = req_tuser;
      in_cmd.main_left     = req_tdata[23:0];
      in_cmd.main_right    = req_tdata[47:24];
      in_cmd.side_left     = req_tdata[71:48];
      in_cmd.side_right    = req_tdata[95:72];
      in_cmd.side_valid    = req_tdata[96];
      in_cmd.request_count = req_tdata[109:97];
      in_cmd.read_offset   = req_tdata[121:110];
   end

   acr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_cmd   (in_cmd),
      .q_valid  (q_valid),
      .q_cmd    (q_cmd),
      .q_pop    (q_pop)
   );

   acr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (res)
   );

   assign rsp_tdata = {res.out_of_window, res.out_side_right, res.out_side_left,
                       res.out_main_right, res.out_main_left, res.valid_ratio,
                       res.side_rms, res.main_rms, res.side_all_present,
                       res.window_frames};

endmodule
`default_nettype wire
